// ===== hdl/tsg_pkg.sv =====
// shared types and constants for the triangle span generator
package tsg_pkg;

  localparam int unsigned XW = 7;
  localparam int unsigned YW = 5;
  localparam int unsigned CW = 32;
  localparam int unsigned SCREEN_WIDTH_DEF = 128;
  localparam int unsigned SCREEN_HEIGHT_DEF = 32;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  typedef struct packed {
    logic [XW-1:0] ax;
    logic [YW-1:0] ay;
    logic [XW-1:0] bx;
    logic [YW-1:0] by;
    logic [XW-1:0] cx;
    logic [YW-1:0] cy;
    logic [CW-1:0] fill_color;
  } tri_t;

  typedef struct packed {
    logic [YW-1:0] row;
    logic [XW-1:0] span_x_a;
    logic [XW-1:0] span_x_b;
    logic [CW-1:0] span_color;
    logic          last_span;
  } span_t;

  // vertices sorted by y, handed from front to back
  typedef struct packed {
    logic [XW-1:0] x0;
    logic [YW-1:0] y0;
    logic [XW-1:0] x1;
    logic [YW-1:0] y1;
    logic [XW-1:0] x2;
    logic [YW-1:0] y2;
    logic [CW-1:0] color;
  } sorted_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MID,
    ST_SLOPE,
    ST_SPAN,
    ST_OUT
  } back_state_e;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_DONE
  } div_state_e;

endpackage

// ===== hdl/triangle_span_generator.sv =====
// top level of the triangle span generator
// one triangle per input transaction on in_valid_i/in_ready_o (tri_t payload);
// spans leave on out_valid_o/out_ready_i (span_t payload), y2-y0+2 per triangle,
// upper half top-down, lower half bottom-up, last_span on the final one.
// setup runs five serial divisions in one shared restoring divider, one
// quotient bit per cycle: start, the quotient bits in turn, done; a division
// whose height is zero is skipped. the split and upper slopes come before the
// upper half, the lower slopes after it; spans leave one per cycle while the
// receiver is ready. per triangle the back end also passes idle and closing states.
// the front sorts vertices by y and holds one triangle ahead, so a new
// triangle is taken while the back end still walks the previous one.
// a stalled receiver holds the span register and freezes the walk; nothing
// is dropped. reset clears all control state; no clearing pass is needed.
module triangle_span_generator #(
  parameter int unsigned FRACTION_BITS = tsg_pkg::FRACTION_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tsg_pkg::tri_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tsg_pkg::span_t out_data_o
);

  logic             q_valid, q_ready;
  tsg_pkg::sorted_t q_data;

  tsg_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  tsg_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data),
    .out_valid_o, .out_ready_i, .out_data_o
  );

  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid |-> (q_data.y0 <= q_data.y1 && q_data.y1 <= q_data.y2))
    else $error("queue entry not sorted by y");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("span changed while stalled");

endmodule

// ===== hdl/tsg_front.sv =====
// front end: accepts triangles and sorts vertices by y
module tsg_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tsg_pkg::tri_t    in_data_i,
  output logic             q_valid_o,
  input  logic             q_ready_i,
  output tsg_pkg::sorted_t q_data_o
);

  tsg_pkg::sorted_t s1, s2, s3;
  logic             full_q;
  tsg_pkg::sorted_t data_q;

  always_comb begin
    s1.x0 = in_data_i.ax; s1.y0 = in_data_i.ay;
    s1.x1 = in_data_i.bx; s1.y1 = in_data_i.by;
    s1.x2 = in_data_i.cx; s1.y2 = in_data_i.cy;
    s1.color = in_data_i.fill_color;
    if (in_data_i.ay > in_data_i.by) begin
      s1.x0 = in_data_i.bx; s1.y0 = in_data_i.by;
      s1.x1 = in_data_i.ax; s1.y1 = in_data_i.ay;
    end
    s2 = s1;
    if (s1.y1 > s1.y2) begin
      s2.x1 = s1.x2; s2.y1 = s1.y2;
      s2.x2 = s1.x1; s2.y2 = s1.y1;
    end
    s3 = s2;
    if (s2.y0 > s2.y1) begin
      s3.x0 = s2.x1; s3.y0 = s2.y1;
      s3.x1 = s2.x0; s3.y1 = s2.y0;
    end
  end

  // one register stage between front and back
  assign in_ready_o = !full_q || q_ready_i;
  assign q_valid_o  = full_q;
  assign q_data_o   = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      full_q <= 1'b1;
    end else if (q_ready_i) begin
      full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= s3;
    end
  end

endmodule

// ===== hdl/tsg_div.sv =====
// restoring signed divider, one quotient bit per cycle, truncating toward zero
module tsg_div #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [NW-1:0] num_i,
  input  logic        [DW-1:0] den_i,
  output logic                 done_o,
  output logic signed [NW-1:0] quo_o,
  output logic                 rem_nz_o
);

  localparam int unsigned CNTW = $clog2(NW + 1);

  tsg_pkg::div_state_e state_q, state_d;
  logic [NW-1:0]   mag_q, mag_d;
  logic [DW:0]     rem_q, rem_d;
  logic [DW-1:0]   den_q;
  logic            neg_q;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [DW:0]     trial;

  always_comb begin
    state_d = state_q;
    case (state_q)
      tsg_pkg::DV_IDLE: if (start_i) state_d = tsg_pkg::DV_RUN;
      tsg_pkg::DV_RUN:  if (cnt_q == CNTW'(NW - 1)) state_d = tsg_pkg::DV_DONE;
      tsg_pkg::DV_DONE: state_d = start_i ? tsg_pkg::DV_RUN : tsg_pkg::DV_IDLE;
      default:          state_d = tsg_pkg::DV_IDLE;
    endcase
  end

  always_comb begin
    trial = {rem_q[DW-1:0], mag_q[NW-1]};
    rem_d = trial;
    mag_d = {mag_q[NW-2:0], 1'b0};
    if (trial >= {1'b0, den_q}) begin
      rem_d    = trial - {1'b0, den_q};
      mag_d[0] = 1'b1;
    end
    cnt_d = cnt_q + CNTW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsg_pkg::DV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (start_i) cnt_q <= '0;
      else if (state_q == tsg_pkg::DV_RUN) cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= num_i[NW-1] ? NW'(-num_i) : num_i;
      neg_q <= num_i[NW-1];
      den_q <= den_i;
      rem_q <= '0;
    end else if (state_q == tsg_pkg::DV_RUN) begin
      mag_q <= mag_d;
      rem_q <= rem_d;
    end
  end

  assign done_o   = state_q == tsg_pkg::DV_DONE;
  assign quo_o    = neg_q ? -$signed(mag_q) : $signed(mag_q);
  assign rem_nz_o = rem_q != '0;

endmodule

// ===== hdl/tsg_back.sv =====
// back end: split point, slopes and span walk
module tsg_back #(
  parameter int unsigned FRACTION_BITS = tsg_pkg::FRACTION_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_ready_o,
  input  tsg_pkg::sorted_t q_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tsg_pkg::span_t   out_data_o
);

  localparam int unsigned XW = tsg_pkg::XW;
  localparam int unsigned YW = tsg_pkg::YW;
  // accumulator: sign + integer part + fraction, margin for overshoot
  localparam int unsigned AW = XW + FRACTION_BITS + 3;
  localparam int unsigned DW = YW + 1;
  localparam logic [XW-1:0] XMAX = XW'(tsg_pkg::SCREEN_WIDTH_DEF - 1);

  tsg_pkg::back_state_e state_q, state_d;
  tsg_pkg::sorted_t v_q;
  logic [XW-1:0]        mid_q;
  logic signed [AW-1:0] s1_q, s2_q, xa_q, xb_q;
  logic [YW-1:0]        y_q;
  logic                 lower_q;
  logic [1:0]           sel_q;
  logic                 out_full_q;
  tsg_pkg::span_t       out_q;

  logic                 div_start;
  logic signed [AW-1:0] div_num, div_quo;
  logic [DW-1:0]        div_den;
  logic                 div_done, div_rnz;

  tsg_div #(.NW(AW), .DW(DW)) u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_nz_o(div_rnz)
  );

  logic signed [AW-1:0] sx0, sx1, sx2, smid, dxa;
  logic [DW-1:0]        hu, hl, hfull;
  logic                 span_fire, last_now, row_end;

  assign sx0  = AW'(signed'({1'b0, v_q.x0}));
  assign sx1  = AW'(signed'({1'b0, v_q.x1}));
  assign sx2  = AW'(signed'({1'b0, v_q.x2}));
  assign smid = AW'(signed'({1'b0, mid_q}));
  assign hu    = DW'(v_q.y1) - DW'(v_q.y0);
  assign hl    = DW'(v_q.y2) - DW'(v_q.y1);
  assign hfull = DW'(v_q.y2) - DW'(v_q.y0);

  // divide job for each setup step: 0 split, 1..2 upper slopes, 3..4 lower slopes
  logic [2:0] job_q;
  always_comb begin
    dxa = (sx2 - sx0) * AW'(signed'({1'b0, hu}));
    div_num = dxa;
    div_den = hfull;
    case (job_q)
      3'd1: begin div_num = (sx1 - sx0) <<< FRACTION_BITS;  div_den = hu; end
      3'd2: begin div_num = (smid - sx0) <<< FRACTION_BITS; div_den = hu; end
      3'd3: begin div_num = (sx2 - sx1) <<< FRACTION_BITS;  div_den = hl; end
      3'd4: begin div_num = (sx2 - smid) <<< FRACTION_BITS; div_den = hl; end
      default: ;
    endcase
  end

  logic job_zero;
  assign job_zero = div_den == '0;

  function automatic logic [XW-1:0] x_of(input logic signed [AW-1:0] acc,
                                           input logic [XW-1:0] xmax);
    logic signed [AW-1:0] v;
    v = acc >>> FRACTION_BITS;
    if (acc < 0) return '0;
    if (v > AW'(signed'({1'b0, xmax}))) return xmax;
    return v[XW-1:0];
  endfunction

  assign row_end   = lower_q ? (y_q == v_q.y1) : (y_q == v_q.y1);
  assign last_now  = lower_q && (y_q == v_q.y1);
  assign span_fire = state_q == tsg_pkg::ST_SPAN && (!out_full_q || out_ready_i);
  assign q_ready_o = state_q == tsg_pkg::ST_IDLE;
  assign div_start = (state_q == tsg_pkg::ST_MID || state_q == tsg_pkg::ST_SLOPE)
                     && sel_q == 2'd0 && !job_zero;

  always_comb begin
    state_d = state_q;
    case (state_q)
      tsg_pkg::ST_IDLE:  if (q_valid_i) state_d = tsg_pkg::ST_MID;
      tsg_pkg::ST_MID:   if (job_zero || div_done) state_d = tsg_pkg::ST_SLOPE;
      tsg_pkg::ST_SLOPE: if ((job_zero && sel_q == 2'd0 || div_done)
                             && (job_q == 3'd2 || job_q == 3'd4))
                           state_d = tsg_pkg::ST_SPAN;
      tsg_pkg::ST_SPAN:  if (span_fire && row_end)
                           state_d = lower_q ? tsg_pkg::ST_OUT : tsg_pkg::ST_SLOPE;
      tsg_pkg::ST_OUT:   state_d = tsg_pkg::ST_IDLE;
      default:           state_d = tsg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tsg_pkg::ST_IDLE;
      job_q      <= '0;
      sel_q      <= '0;
      lower_q    <= 1'b0;
      out_full_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (span_fire) out_full_q <= 1'b1;
      else if (out_ready_i) out_full_q <= 1'b0;
      case (state_q)
        tsg_pkg::ST_IDLE: begin
          job_q   <= '0;
          sel_q   <= '0;
          lower_q <= 1'b0;
        end
        tsg_pkg::ST_MID, tsg_pkg::ST_SLOPE: begin
          if (job_zero && sel_q == 2'd0 || div_done) begin
            job_q <= job_q + 3'd1;
            sel_q <= '0;
          end else begin
            sel_q <= 2'd1;
          end
        end
        tsg_pkg::ST_SPAN: if (span_fire && row_end) lower_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == tsg_pkg::ST_IDLE && q_valid_i) v_q <= q_data_i;
    if (state_q == tsg_pkg::ST_MID && (job_zero || div_done)) begin
      // floored split, zero height uses x0
      mid_q <= job_zero ? v_q.x0 : XW'(sx0 + (div_rnz && dxa < 0 ?
               div_quo - AW'(1) : div_quo));
    end
    if (state_q == tsg_pkg::ST_SLOPE && (job_zero && sel_q == 2'd0 || div_done)) begin
      if (job_q == 3'd1 || job_q == 3'd3) s1_q <= job_zero ? '0 : div_quo;
      else                                s2_q <= job_zero ? '0 : div_quo;
      if (job_q == 3'd2) begin
        xa_q <= sx0 <<< FRACTION_BITS; xb_q <= sx0 <<< FRACTION_BITS; y_q <= v_q.y0;
      end
      if (job_q == 3'd4) begin
        xa_q <= sx2 <<< FRACTION_BITS; xb_q <= sx2 <<< FRACTION_BITS; y_q <= v_q.y2;
      end
    end
    if (span_fire) begin
      out_q.row        <= y_q;
      out_q.span_x_a   <= x_of(xa_q, XMAX);
      out_q.span_x_b   <= x_of(xb_q, XMAX);
      out_q.span_color <= v_q.color;
      out_q.last_span  <= last_now;
      if (lower_q) begin
        xa_q <= xa_q - s1_q; xb_q <= xb_q - s2_q; y_q <= y_q - YW'(1);
      end else begin
        xa_q <= xa_q + s1_q; xb_q <= xb_q + s2_q; y_q <= y_q + YW'(1);
      end
    end
  end

  assign out_valid_o = out_full_q;
  assign out_data_o  = out_q;

endmodule

// ===== test/triangle_span_generator_tb.sv =====
// self-checking testbench for the triangle span generator
module triangle_span_generator_tb;

  localparam int XW = tsg_pkg::XW;
  localparam int YW = tsg_pkg::YW;
  localparam int FRAC = 16;
  localparam int XMAX = 127;
  localparam int STALL_LIMIT = 20000;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid;
  logic            in_ready;
  tsg_pkg::tri_t   in_data;
  logic            out_valid;
  logic            out_ready;
  tsg_pkg::span_t  out_data;

  tsg_pkg::span_t  span_q[$];
  int     err_cnt;
  int     send_idle_pct;
  int     recv_stall_pct;
  int     quiet_cycles;
  bit     timed_out;

  triangle_span_generator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [XW-1:0] acc_to_x(longint acc);
    longint v;
    if (acc < 0) return '0;
    v = acc >>> FRAC;
    if (v > XMAX) v = XMAX;
    return v[XW-1:0];
  endfunction

  function automatic longint edge_slope(longint dx, longint dy);
    if (dy == 0) return 0;
    return (dx * (longint'(1) << FRAC)) / dy;
  endfunction

  // sort by y, walk both halves and queue every expected span
  task automatic predict_spans(tsg_pkg::tri_t t);
    longint x0, y0, x1, y1, x2, y2, tmp, mid_x, num, den, s1, s2, xa, xb, y;
    tsg_pkg::span_t s;
    x0 = longint'(t.ax); y0 = longint'(t.ay);
    x1 = longint'(t.bx); y1 = longint'(t.by);
    x2 = longint'(t.cx); y2 = longint'(t.cy);
    if (y0 > y1) begin
      tmp = y0; y0 = y1; y1 = tmp; tmp = x0; x0 = x1; x1 = tmp;
    end
    if (y1 > y2) begin
      tmp = y1; y1 = y2; y2 = tmp; tmp = x1; x1 = x2; x2 = tmp;
    end
    if (y0 > y1) begin
      tmp = y0; y0 = y1; y1 = tmp; tmp = x0; x0 = x1; x1 = tmp;
    end
    den = y2 - y0;
    if (den == 0) begin
      mid_x = x0;
    end else begin
      num = (x2 - x0) * (y1 - y0);
      tmp = num / den;
      if (num % den != 0 && num < 0) tmp -= 1;
      mid_x = x0 + tmp;
    end
    s.span_color = t.fill_color;
    s1 = edge_slope(x1 - x0, y1 - y0);
    s2 = edge_slope(mid_x - x0, y1 - y0);
    xa = x0 << FRAC;
    xb = xa;
    for (y = y0; y <= y1; y++) begin
      s.row = y[YW-1:0]; s.span_x_a = acc_to_x(xa); s.span_x_b = acc_to_x(xb);
      s.last_span = 1'b0;
      span_q.push_back(s);
      xa += s1; xb += s2;
    end
    s1 = edge_slope(x2 - x1, y2 - y1);
    s2 = edge_slope(x2 - mid_x, y2 - y1);
    xa = x2 << FRAC;
    xb = xa;
    for (y = y2; y >= y1; y--) begin
      s.row = y[YW-1:0]; s.span_x_a = acc_to_x(xa); s.span_x_b = acc_to_x(xb);
      s.last_span = (y == y1);
      span_q.push_back(s);
      xa -= s1; xb -= s2;
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    err_cnt++;
  endtask

  // one transaction on the input channel, with random idle before it
  task automatic send_triangle(tsg_pkg::tri_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_data  <= t;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    predict_spans(t);
    @(negedge clk_i);
  endtask

  function automatic tsg_pkg::tri_t rand_triangle();
    tsg_pkg::tri_t t;
    t.ax = XW'($urandom); t.ay = YW'($urandom);
    t.bx = XW'($urandom); t.by = YW'($urandom);
    t.cx = XW'($urandom); t.cy = YW'($urandom);
    t.fill_color = $urandom;
    return t;
  endfunction

  function automatic tsg_pkg::tri_t make_tri(int ax, int ay, int bx, int by, int cx,
                                             int cy, logic [31:0] c);
    tsg_pkg::tri_t t;
    t.ax = XW'(ax); t.ay = YW'(ay); t.bx = XW'(bx); t.by = YW'(by);
    t.cx = XW'(cx); t.cy = YW'(cy);
    t.fill_color = c;
    return t;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (span_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_triangle(make_tri(0, 0, 0, 0, 0, 0, 32'h0));
    send_triangle(make_tri(127, 31, 127, 31, 127, 31, 32'hffff_ffff));
    send_triangle(make_tri(0, 0, 127, 31, 64, 15, 32'h1234_5678));
    send_triangle(make_tri(127, 0, 0, 31, 0, 0, 32'haaaa_5555));
    send_triangle(make_tri(10, 5, 100, 5, 60, 5, 32'h5555_aaaa));
    send_triangle(make_tri(0, 31, 127, 0, 127, 31, 32'h0f0f_0f0f));
    send_triangle(make_tri(50, 20, 10, 20, 90, 2, 32'hdead_beef));
    send_triangle(make_tri(50, 2, 10, 20, 90, 20, 32'hcafe_f00d));
    send_triangle(make_tri(127, 0, 0, 1, 127, 31, 32'h8000_0001));
    send_triangle(make_tri(0, 0, 127, 1, 0, 31, 32'h7fff_fffe));
    send_triangle(make_tri(3, 7, 120, 8, 64, 30, 32'h0000_ffff));
    send_triangle(make_tri(64, 30, 3, 7, 120, 8, 32'hffff_0000));
    send_triangle(make_tri(1, 0, 126, 31, 126, 30, 32'h1));
    // sender holds off until every expected span is back
    wait_drained();
    send_triangle(make_tri(127, 16, 0, 0, 0, 31, 32'h2468_ace0));
  endtask

  task automatic test_random(int n, int idle, int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (n) send_triangle(rand_triangle());
  endtask

  // receiver stall and output checking
  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    tsg_pkg::span_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (span_q.size() == 0) begin
        report_mismatch("unexpected span", longint'(out_data), longint'(0));
      end else begin
        want = span_q.pop_front();
        if (out_data.row != want.row)
          report_mismatch("row", longint'(out_data.row), longint'(want.row));
        if (out_data.span_x_a != want.span_x_a)
          report_mismatch("span_x_a", longint'(out_data.span_x_a),
                          longint'(want.span_x_a));
        if (out_data.span_x_b != want.span_x_b)
          report_mismatch("span_x_b", longint'(out_data.span_x_b),
                          longint'(want.span_x_b));
        if (out_data.span_color != want.span_color)
          report_mismatch("span_color", longint'(out_data.span_color),
                          longint'(want.span_color));
        if (out_data.last_span != want.last_span)
          report_mismatch("last_span", longint'(out_data.last_span),
                          longint'(want.last_span));
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    err_cnt = 0;
    quiet_cycles = 0;
    timed_out = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(80, 0, 0);
    test_random(80, 71, 0);
    test_random(80, 0, 71);
    test_random(80, 10, 10);
    wait_drained();
    recv_stall_pct = 0;
    repeat (300) @(posedge clk_i);
    if (err_cnt == 0 && span_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
